// ===== design/rst_pkg.sv =====
// rst_pkg: shared constants, codes and types for the RSSI sample tracker.
// No dependencies.
package rst_pkg;

  localparam int BLOCK_SAMPLES_DEF = 32;
  localparam int BUCKETS_DEF       = 6;

  localparam int STAT_SCALE   = 10000;
  localparam int PACKET_TICKS = 40;
  localparam int TOP_LEVEL    = -81;
  localparam int LEVEL_STEP   = 5;
  localparam int FLOOR_LEVEL  = -106;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_REPORT  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_STAMP   = 3'd0,
    K_SAMPLE  = 3'd1,
    K_MEAN    = 3'd2,
    K_VAR     = 3'd3,
    K_TOTAL   = 3'd4,
    K_BUCKET  = 3'd5,
    K_NOTHING = 3'd6
  } kind_t;

  // word passed from front to back
  typedef struct packed {
    logic [1:0]        command;
    logic signed [7:0] smp;
  } qword_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AGG_DIV,
    S_AGG_UPD,
    S_CLEAR,
    S_DRAIN,
    S_REP_DIV,
    S_REP
  } state_t;

endpackage

// ===== design/rst_front.sv =====
// rst_front: accepts input words, resolves the sample value, feeds a
// two-entry queue toward the back end. Depends on rst_pkg.
module rst_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic signed [7:0]    rssi,
  input  logic                 rssi_valid,
  output logic                 q_valid,
  input  logic                 q_ready,
  output rst_pkg::qword_t      q_word
);

  rst_pkg::qword_t slot [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;
  logic            pop;
  rst_pkg::qword_t w_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_word   = slot[rd_ptr];

  always_comb begin
    w_in.command = command;
    w_in.smp     = rssi_valid ? rssi : -8'sd1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= w_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/rst_div.sv =====
// rst_div: unsigned 32-bit division by the statistics scale or by the packet
// tick period, through reciprocal multiplication. Depends on nothing.
module rst_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic        by_ticks,
  output logic        busy,
  output logic [31:0] quotient
);

  // x/10000 = (x*0xD1B71759)>>45; x/40 = ((x>>3)*0xCCCCCCCD)>>34
  localparam logic [31:0] RECIP_SCALE = 32'hD1B71759;
  localparam logic [31:0] RECIP_FIVE  = 32'hCCCCCCCD;

  logic [31:0] opnd;
  logic [31:0] recip;
  logic        ticks;
  logic [63:0] prod;
  logic [31:0] q;
  logic [1:0]  cnt;

  assign busy     = (cnt != 2'd0);
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (start) begin
      cnt <= 2'd2;
    end else if (busy) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      opnd  <= by_ticks ? {3'd0, dividend[31:3]} : dividend;
      recip <= by_ticks ? RECIP_FIVE : RECIP_SCALE;
      ticks <= by_ticks;
    end
    if (cnt == 2'd2) prod <= {32'd0, opnd} * {32'd0, recip};
    if (cnt == 2'd1) q <= ticks ? {2'd0, prod[63:34]} : {13'd0, prod[63:45]};
  end

endmodule

// ===== design/rst_back.sv =====
// rst_back: executes queued words: capture buffers, statistics, buckets,
// drains and reports. Depends on rst_pkg and rst_div.
module rst_back #(
  parameter int BLOCK_SAMPLES = rst_pkg::BLOCK_SAMPLES_DEF,
  parameter int BUCKETS       = rst_pkg::BUCKETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               mode,
  input  logic               q_valid,
  output logic               q_ready,
  input  rst_pkg::qword_t    q_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [4:0]         index,
  output logic signed [32:0] value,
  output logic               last
);

  localparam int PW = $clog2(BLOCK_SAMPLES);
  localparam int AW = PW + 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = $clog2(BLOCK_SAMPLES + BUCKETS + 4);

  // sample memory, cleared by a sweep on restart
  logic [7:0] mem [2*BLOCK_SAMPLES];
  logic [7:0] mem_rd;

  rst_pkg::state_t state, state_next;

  logic [15:0]        stamp [2];
  logic [PW-1:0]      wpos;
  logic               fill_buf;
  logic               pend;
  logic               rdy_buf;
  logic [31:0]        counter;
  logic [31:0]        mean;
  logic [31:0]        var_r;
  logic [31:0]        blast [BUCKETS];
  logic [15:0]        bpk   [BUCKETS];
  logic signed [7:0]  cur;
  logic [RW-1:0]      step;
  logic [AW-1:0]      clr;

  // divider shared by stats, elapsed/40 and reports
  logic        dstart;
  logic [31:0] ddvd;
  logic        dsel;
  logic        dbusy;
  logic [31:0] dq;
  logic        dneg;
  logic [31:0] qmean;
  logic [31:0] qvar;
  logic [BW-1:0] bidx;
  logic [1:0]  phase;

  rst_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(ddvd), .by_ticks(dsel),
    .busy(dbusy), .quotient(dq)
  );

  logic [31:0] sq;
  logic        out_busy;
  logic        emit;
  logic [2:0]  e_kind;
  logic [4:0]  e_index;
  logic signed [32:0] e_value;
  logic        e_last;

  assign out_busy = out_valid && !out_ready;
  assign q_ready  = (state == rst_pkg::S_IDLE) && !dbusy;

  logic signed [31:0] smean;
  logic signed [31:0] svar;
  logic [31:0]        mag;
  logic signed [31:0] diff;
  logic signed [31:0] thr;
  logic               hit;
  logic               hit_n;
  logic signed [31:0] thr_n;
  logic signed [7:0]  mem_rd_s;

  assign smean = mean;
  assign svar  = var_r;
  assign sq    = dneg ? (~dq + 32'd1) : dq;
  assign diff  = 32'(cur) - qmean;
  assign mem_rd_s = mem_rd;

  always_comb begin
    thr = 32'(rst_pkg::TOP_LEVEL) - 32'(rst_pkg::LEVEL_STEP) * 32'(bidx);
    hit = (32'(cur) >= 32'(rst_pkg::FLOOR_LEVEL)) && ($signed(32'(cur)) > thr);
  end

  always_comb begin
    thr_n = thr - 32'(rst_pkg::LEVEL_STEP);
    hit_n = (32'(cur) >= 32'(rst_pkg::FLOOR_LEVEL)) && ($signed(32'(cur)) > thr_n);
  end

  // phase in S_AGG_DIV: 0 mean, 1 variance; 2 buckets in S_AGG_UPD
  // counter has already advanced past the sample being aggregated
  always_comb begin
    state_next = state;
    dstart = 1'b0;
    ddvd   = 32'd0;
    dsel   = 1'b0;
    mag    = 32'd0;
    emit   = 1'b0;
    e_kind = rst_pkg::K_NOTHING;
    e_index = 5'd0;
    e_value = 33'sd0;
    e_last  = 1'b0;
    case (state)
      rst_pkg::S_IDLE: begin
        if (q_valid && q_ready) begin
          case (q_word.command)
            rst_pkg::CMD_SAMPLE: begin
              if (!mode) begin
                state_next = rst_pkg::S_IDLE;
              end else begin
                mag = smean[31] ? (~mean + 32'd1) : mean;
                dstart = 1'b1;
                ddvd = mag;
                state_next = rst_pkg::S_AGG_DIV;
              end
            end
            rst_pkg::CMD_REPORT: begin
              if (!mode) begin
                if (pend) state_next = rst_pkg::S_DRAIN;
                else if (!out_busy) begin
                  emit = 1'b1;
                  e_kind = rst_pkg::K_NOTHING;
                  e_last = 1'b1;
                end else state_next = rst_pkg::S_REP;
              end else begin
                mag = smean[31] ? (~mean + 32'd1) : mean;
                dstart = 1'b1;
                ddvd = mag;
                state_next = rst_pkg::S_REP_DIV;
              end
            end
            rst_pkg::CMD_RESTART: state_next = rst_pkg::S_CLEAR;
            default: state_next = rst_pkg::S_IDLE;
          endcase
        end
      end
      rst_pkg::S_AGG_DIV: begin
        if (!dbusy) begin
          if (phase == 2'd0) begin
            mag = svar[31] ? (~var_r + 32'd1) : var_r;
            dstart = 1'b1;
            ddvd = mag;
          end else begin
            state_next = rst_pkg::S_AGG_UPD;
            if (hit) begin
              dstart = 1'b1;
              ddvd = counter - 32'd1 - blast[bidx];
              dsel = 1'b1;
            end
          end
        end
      end
      rst_pkg::S_AGG_UPD: begin
        if (!dbusy) begin
          if (32'(bidx) == 32'(BUCKETS - 1)) state_next = rst_pkg::S_IDLE;
          else if (hit_n) begin
            dstart = 1'b1;
            ddvd = counter - 32'd1 - blast[bidx + BW'(1)];
            dsel = 1'b1;
          end
        end
      end
      rst_pkg::S_CLEAR: begin
        if (clr == AW'(2*BLOCK_SAMPLES - 1)) state_next = rst_pkg::S_IDLE;
      end
      rst_pkg::S_DRAIN: begin
        if (!out_busy && step != RW'(0)) begin
          emit = 1'b1;
          e_kind = rst_pkg::K_SAMPLE;
          e_index = 5'(step - RW'(1));
          e_value = 33'(mem_rd_s);
          e_last = (step == RW'(BLOCK_SAMPLES));
          if (e_last) state_next = rst_pkg::S_IDLE;
        end else if (!out_busy) begin
          emit = 1'b1;
          e_kind = rst_pkg::K_STAMP;
          e_value = 33'(stamp[rdy_buf]);
        end
      end
      rst_pkg::S_REP_DIV: begin
        if (!dbusy) begin
          if (phase == 2'd0) begin
            mag = svar[31] ? (~var_r + 32'd1) : var_r;
            dstart = 1'b1;
            ddvd = mag;
          end else if (phase == 2'd1) begin
            dstart = 1'b1;
            ddvd = counter;
            dsel = 1'b1;
          end else begin
            state_next = rst_pkg::S_REP;
          end
        end
      end
      rst_pkg::S_REP: begin
        if (!out_busy) begin
          emit = 1'b1;
          if (!mode) begin
            e_kind = rst_pkg::K_NOTHING;
            e_last = 1'b1;
            state_next = rst_pkg::S_IDLE;
          end else if (step == RW'(0)) begin
            e_kind = rst_pkg::K_MEAN;
            e_value = 33'(signed'(qmean));
          end else if (step == RW'(1)) begin
            e_kind = rst_pkg::K_VAR;
            e_value = 33'(signed'(qvar));
          end else if (step == RW'(2)) begin
            e_kind = rst_pkg::K_TOTAL;
            e_value = {1'b0, dq};
          end else begin
            e_kind = rst_pkg::K_BUCKET;
            e_index = 5'(step - RW'(3));
            e_value = 33'(bpk[BW'(step - RW'(3))]);
            e_last = (step == RW'(BUCKETS + 2));
            if (e_last) state_next = rst_pkg::S_IDLE;
          end
        end
      end
      default: state_next = rst_pkg::S_IDLE;
    endcase
  end

  // capture path
  logic               cap;
  logic               full;
  logic               nfill;
  assign cap  = (state == rst_pkg::S_IDLE) && q_valid && q_ready &&
                (q_word.command == rst_pkg::CMD_SAMPLE) && !mode;
  assign full = (wpos == PW'(BLOCK_SAMPLES - 1));
  assign nfill = pend ? fill_buf : ~fill_buf;

  // memory port: write on capture or clear, read for drain
  logic [AW-1:0] raddr;
  always_comb begin
    if (state == rst_pkg::S_DRAIN && emit && step != RW'(BLOCK_SAMPLES))
      raddr = {rdy_buf, PW'(step)};
    else if (state == rst_pkg::S_DRAIN)
      raddr = {rdy_buf, PW'(step - RW'(1))};
    else
      raddr = {rdy_buf, PW'(0)};
  end

  always_ff @(posedge clk) begin
    if (state == rst_pkg::S_CLEAR) mem[clr] <= 8'd0;
    else if (cap) mem[{fill_buf, wpos}] <= q_word.smp;
    mem_rd <= mem[raddr];
  end

  logic [63:0] dsq;
  assign dsq = 64'($signed(diff) * $signed(diff));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rst_pkg::S_CLEAR;
      clr <= '0;
      step <= '0;
      phase <= 2'd0;
      bidx <= '0;
      wpos <= '0;
      fill_buf <= 1'b0;
      pend <= 1'b0;
      rdy_buf <= 1'b0;
      counter <= 32'd0;
      mean <= 32'd0;
      var_r <= 32'd0;
      stamp[0] <= 16'd0;
      stamp[1] <= 16'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < BUCKETS; i++) begin
        blast[i] <= 32'd0;
        bpk[i] <= 16'd0;
      end
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (emit) begin
        out_valid <= 1'b1;
        kind <= e_kind;
        index <= e_index;
        value <= e_value;
        last <= e_last;
      end
      case (state)
        rst_pkg::S_IDLE: begin
          step <= '0;
          phase <= 2'd0;
          bidx <= '0;
          clr <= '0;
          if (q_valid && q_ready) begin
            cur <= q_word.smp;
            dneg <= smean[31];
            if (q_word.command == rst_pkg::CMD_SAMPLE) begin
              counter <= counter + 32'd1;
              if (cap) begin
                wpos <= full ? PW'(0) : wpos + PW'(1);
                if (full) begin
                  if (!pend) begin
                    pend <= 1'b1;
                    rdy_buf <= fill_buf;
                    fill_buf <= ~fill_buf;
                  end
                  stamp[nfill] <= counter[15:0];
                end
              end
            end
          end
        end
        rst_pkg::S_AGG_DIV, rst_pkg::S_REP_DIV: begin
          if (!dbusy) begin
            phase <= phase + 2'd1;
            if (phase == 2'd0) begin
              qmean <= sq;
              dneg <= svar[31];
            end else if (phase == 2'd1) begin
              qvar <= sq;
              dneg <= 1'b0;
            end
          end
        end
        rst_pkg::S_AGG_UPD: begin
          if (!dbusy) begin
            if (phase == 2'd2) begin
              // first pass: commit mean/variance (counter already advanced)
              mean <= mean + diff;
              var_r <= var_r - qvar + dsq[31:0];
              phase <= 2'd3;
            end
            if (hit) begin
              bpk[bidx] <= bpk[bidx] + dq[15:0];
              blast[bidx] <= counter - 32'd1;
            end
            bidx <= bidx + BW'(1);
          end
        end
        rst_pkg::S_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == '0) begin
            wpos <= '0;
            pend <= 1'b0;
            counter <= 32'd0;
            stamp[0] <= 16'd0;
            stamp[1] <= 16'd0;
            for (int i = 0; i < BUCKETS; i++) begin
              blast[i] <= 32'd0;
              bpk[i] <= 16'd0;
            end
          end
        end
        rst_pkg::S_DRAIN: begin
          if (emit) begin
            step <= step + RW'(1);
            if (e_last) pend <= 1'b0;
          end
        end
        rst_pkg::S_REP: begin
          if (emit) step <= step + RW'(1);
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/rssi_sample_tracker.sv =====
// rssi_sample_tracker: top level; front queue plus back-end executor.
// Depends on rst_pkg, rst_front, rst_back, rst_div.
//
//  channel | direction | fields
//  in      | input     | command, rssi, rssi_valid
//  out     | output    | kind, index, value, last
//  cfg     | input     | cfg_data (mode)
//
// Capture sample and unused command stay in the idle state. Restart sweeps the
// 2*BLOCK_SAMPLES-word sample memory, also after reset.
// Aggregate sample: accept, the mean and variance quotients, then each bucket in
// turn, with a division for a bucket that takes a count.
// Aggregate report: the mean, variance and total quotients, then 3+BUCKETS words.
// Drain: one word per cycle unless out_ready stalls it, BLOCK_SAMPLES+1 words.
// A two-word queue lets input be taken while the back end stalls on out_ready.
module rssi_sample_tracker #(
  parameter int BLOCK_SAMPLES = rst_pkg::BLOCK_SAMPLES_DEF,
  parameter int BUCKETS       = rst_pkg::BUCKETS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic signed [7:0]  rssi,
  input  logic               rssi_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [4:0]         index,
  output logic signed [32:0] value,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  logic            mode;
  logic            q_valid;
  logic            q_ready;
  rst_pkg::qword_t q_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (cfg_valid) mode <= cfg_data;
  end

  rst_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .rssi(rssi), .rssi_valid(rssi_valid),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  rst_back #(.BLOCK_SAMPLES(BLOCK_SAMPLES), .BUCKETS(BUCKETS)) u_back (
    .clk(clk), .rst(rst), .mode(mode), .q_valid(q_valid), .q_ready(q_ready),
    .q_word(q_word), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .index(index), .value(value), .last(last)
  );

endmodule

// ===== design/rst_checker.sv =====
// rst_checker: port-level checks for rssi_sample_tracker, bound to the top.
// Depends on rst_pkg.
module rst_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  kind,
  input logic [4:0]  index,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind))
    else $error("output word dropped");

  a_nothing_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == rst_pkg::K_NOTHING |-> last)
    else $error("nothing-ready word not last");

  a_stamp_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == rst_pkg::K_STAMP |-> !last && index == 5'd0)
    else $error("stamp word malformed");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind != 3'd7)
    else $error("bad kind");

endmodule

bind rssi_sample_tracker rst_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .kind(kind), .index(index), .last(last)
);

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for rssi_sample_tracker; predicts capture blocks,
// aggregate statistics and buckets per input word. Depends on rst_pkg.
module tb_top;

  localparam int NBLK = 32;
  localparam int NBKT = 6;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] smp;
    logic       ok;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  idx;
    logic [32:0] val;
    logic        lst;
  } res_word_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] command = rst_pkg::CMD_SAMPLE;
  logic signed [7:0] rssi = 0;
  logic rssi_valid = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [2:0] kind;
  logic [4:0] index;
  logic signed [32:0] value;
  logic last;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_data = 0;

  rssi_sample_tracker u_top (.*);

  always #5 clk = ~clk;

  in_word_t  pending_words[$];
  res_word_t expected_results[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  int hold_cycles = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int cycle_count = 0;
  int levels[6] = '{-80, -81, -106, -107, 127, -128};

  // predictor state
  bit        agg_mode;
  bit [7:0]  store_mem[2*NBLK];
  bit [15:0] stamp[2];
  int        wpos;
  bit        fill_buf, rdy_pend, rdy_buf;
  bit [31:0] counter, mean_s, var_s;
  bit [31:0] bkt_time[NBKT];
  bit [15:0] bkt_pkts[NBKT];

  task automatic clear_capture();
    foreach (store_mem[i]) store_mem[i] = 0;
    stamp[0] = 0; stamp[1] = 0;
    wpos = 0; rdy_pend = 0; counter = 0;
    foreach (bkt_time[i]) begin
      bkt_time[i] = 0; bkt_pkts[i] = 0;
    end
  endtask

  task automatic push_result(rst_pkg::kind_t k, int i, longint v, bit l);
    res_word_t r;
    r.kind = k; r.idx = i[4:0]; r.val = v[32:0]; r.lst = l;
    expected_results.push_back(r);
  endtask

  task automatic predict_tracker(in_word_t w);
    int s, lvl;
    longint m, vr, d;
    bit [31:0] el;
    if (w.cmd == rst_pkg::CMD_SAMPLE) begin
      s = w.ok ? $signed(w.smp) : -1;
      if (!agg_mode) begin
        store_mem[fill_buf*NBLK + wpos] = s[7:0];
        wpos++;
        if (wpos >= NBLK) begin
          if (!rdy_pend) begin
            rdy_pend = 1; rdy_buf = fill_buf; fill_buf = ~fill_buf;
          end
          wpos = 0;
          stamp[fill_buf] = counter[15:0];
        end
      end else begin
        m = $signed(mean_s); vr = $signed(var_s);
        d = s - m / 10000;
        d = longint'($signed(d[31:0]));
        mean_s = 32'(m + d);
        var_s = 32'(vr - vr / 10000 + d * d);
        if (s >= rst_pkg::FLOOR_LEVEL) begin
          lvl = rst_pkg::TOP_LEVEL;
          for (int i = 0; i < NBKT; i++) begin
            if (s > lvl) begin
              el = counter - bkt_time[i];
              bkt_pkts[i] = 16'(bkt_pkts[i] + el / 40);
              bkt_time[i] = counter;
            end
            lvl -= rst_pkg::LEVEL_STEP;
          end
        end
      end
      counter++;
    end else if (w.cmd == rst_pkg::CMD_REPORT) begin
      if (!agg_mode) begin
        if (!rdy_pend) push_result(rst_pkg::K_NOTHING, 0, 0, 1);
        else begin
          push_result(rst_pkg::K_STAMP, 0, stamp[rdy_buf], 0);
          for (int i = 0; i < NBLK; i++)
            push_result(rst_pkg::K_SAMPLE, i,
                        longint'($signed(store_mem[rdy_buf*NBLK + i])), i == NBLK-1);
          rdy_pend = 0;
        end
      end else begin
        push_result(rst_pkg::K_MEAN, 0, longint'($signed(mean_s)) / 10000, 0);
        push_result(rst_pkg::K_VAR, 0, longint'($signed(var_s)) / 10000, 0);
        push_result(rst_pkg::K_TOTAL, 0, counter / 40, 0);
        for (int i = 0; i < NBKT; i++)
          push_result(rst_pkg::K_BUCKET, i, bkt_pkts[i], i == NBKT-1);
      end
    end else if (w.cmd == rst_pkg::CMD_RESTART) clear_capture();
  endtask

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (!in_valid || in_ready) begin
        if (in_valid && in_ready) predict_tracker({command, rssi, rssi_valid});
        if (pending_words.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_valid <= 1;
          {command, rssi, rssi_valid} <= pending_words.pop_front();
        end else in_valid <= 0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_ready <= 0;
      end else if (hold_req && !hold_done) begin
        hold_cycles <= 300;
        hold_done <= 1;
        out_ready <= 0;
      end else out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    res_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected word kind=%0d index=%0d value=%0d", kind, index, value);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (kind !== e.kind) begin $error("kind exp %0d got %0d", e.kind, kind); errors++; end
        if (index !== e.idx) begin $error("index exp %0d got %0d", e.idx, index); errors++; end
        if (value !== e.val) begin
          $error("value exp %0d got %0d", $signed(e.val), value); errors++;
        end
        if (last !== e.lst) begin $error("last exp %0d got %0d", e.lst, last); errors++; end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("rssi_sample_tracker test failed");
      $finish;
    end
  end

  function automatic in_word_t mk(rst_pkg::cmd_t c, int s, bit ok);
    in_word_t w;
    w.cmd = c; w.smp = s[7:0]; w.ok = ok;
    return w;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    // aggregate samples and restarts finish with no result word
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    @(posedge clk);
    cfg_valid <= 1; cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    agg_mode = m;
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 80)
        pending_words.push_back(mk(rst_pkg::CMD_SAMPLE, $urandom_range(255),
                                   $urandom_range(9) != 0));
      else if (r < 94)
        pending_words.push_back(mk(rst_pkg::CMD_REPORT, $urandom_range(255),
                                   $urandom_range(1)));
      else if (r < 97)
        pending_words.push_back(mk(rst_pkg::CMD_RESTART, $urandom_range(255),
                                   $urandom_range(1)));
      else
        pending_words.push_back(mk(rst_pkg::CMD_NONE, $urandom_range(255),
                                   $urandom_range(1)));
    end
  endtask

  initial begin
    agg_mode = 0; fill_buf = 0; rdy_buf = 0; mean_s = 0; var_s = 0;
    clear_capture();
    repeat (6) @(posedge clk);
    rst <= 0;
    send_idle = 22; recv_idle = 73;
    // directed capture: empty drain, one full block of extremes, drain
    pending_words.push_back(mk(rst_pkg::CMD_REPORT, 0, 0));
    for (int i = 0; i < NBLK; i++)
      pending_words.push_back(mk(rst_pkg::CMD_SAMPLE,
                                 (i%3==0) ? 127 : (i%3==1) ? -128 : 5, i != 4));
    pending_words.push_back(mk(rst_pkg::CMD_NONE, 0, 1));
    pending_words.push_back(mk(rst_pkg::CMD_REPORT, 0, 1));
    wait_drained();
    write_mode(1);
    // directed aggregate: threshold edges, invalid read, report, restart, report
    foreach (levels[i])
      pending_words.push_back(mk(rst_pkg::CMD_SAMPLE, levels[i], 1));
    pending_words.push_back(mk(rst_pkg::CMD_SAMPLE, 33, 0));
    pending_words.push_back(mk(rst_pkg::CMD_REPORT, 0, 0));
    pending_words.push_back(mk(rst_pkg::CMD_RESTART, 0, 0));
    pending_words.push_back(mk(rst_pkg::CMD_REPORT, 0, 0));
    random_phase(60);
    wait_drained();
    write_mode(0);
    send_idle = 73; recv_idle = 22;
    random_phase(150);
    // long receiver hold-off while sender keeps offering
    hold_req = 1;
    random_phase(80);
    wait_drained();
    write_mode(1);
    send_idle = 0; recv_idle = 0;
    random_phase(60);
    wait_drained();
    write_mode(0);
    random_phase(60);
    wait_drained();
    if (errors == 0) $display("rssi_sample_tracker test passed");
    else $display("rssi_sample_tracker test failed");
    $finish;
  end
endmodule

// ===== rssi_sample_tracker.f =====
design/rst_pkg.sv
design/rst_front.sv
design/rst_div.sv
design/rst_back.sv
design/rssi_sample_tracker.sv
design/rst_checker.sv
bench/tb_top.sv
